/* rtl/cil_pkg.sv */
// Shared constants for the cell interleaver: sizes, register map, op codes.
// No dependencies; used by cell_interleaver_core, the checker and the testbench.
`default_nettype none

package cil_pkg;

   localparam int unsigned CIL_MAX_CELLS = 4096;
   localparam int unsigned CIL_MAX_DEPTH = 8;

   // output queue of finished items
   localparam int unsigned CIL_OUT_DEPTH = 4;

   // configuration port
   localparam int unsigned CIL_ADDR_W = 4;
   localparam int unsigned CIL_DATA_W = 32;
   localparam int unsigned CIL_IDX_W  = 2;

   localparam logic [CIL_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
   localparam logic [CIL_IDX_W-1:0] REG_LONG_MODE    = 2'd1;
   localparam logic [CIL_IDX_W-1:0] REG_DEPTH        = 2'd2;

   localparam logic [12:0] RST_FRAME_LENGTH = 13'd4096;
   localparam logic        RST_LONG_MODE    = 1'b0;
   localparam logic [3:0]  RST_DEPTH        = 4'd5;

   // item op codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CELL = 1'b1;

   typedef struct packed {
      logic signed [15:0] out_i;
      logic signed [15:0] out_q;
      logic               frame_end;
   } cil_cell_type;

endpackage

`default_nettype wire

/* rtl/cil_if.sv */
// Valid/ready channel interfaces for the cell interleaver request and result items.
// Depends on nothing beyond plain logic types.
`default_nettype none

interface cil_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic        [11:0] table_index;
   logic        [11:0] table_value;
   logic signed [15:0] in_i;
   logic signed [15:0] in_q;

   modport source (output valid, op, table_index, table_value, in_i, in_q, input ready);
   modport sink   (input valid, op, table_index, table_value, in_i, in_q, output ready);
endinterface

interface cil_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_i;
   logic signed [15:0] out_q;
   logic               frame_end;

   modport source (output valid, out_i, out_q, frame_end, input ready);
   modport sink   (input valid, out_i, out_q, frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/cil_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module cil_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/cell_interleaver_core.sv */
// Frame cell interleaver top level: permutation table, frame store, output queue.
// Depends on cil_pkg, cil_if (cil_req_if, cil_rsp_if) and cil_ram.
//
// Use: req_if carries items. op OP_LOAD writes one permutation entry
// (table_index -> table_value) and gives no result. op OP_CELL delivers one
// I/Q cell, stored into a circular store of depth+1 frames. Once depth frames
// are complete, each cell gives one result on rsp_if: cell perm[p] of the frame
// (p mod depth) older than the newest complete one; frame_end marks p = L-1.
// Short mode uses depth 1. Registers on the csr_ APB port; any write to one of the
// three registers restarts the stream but keeps the table and store contents.
// Throughput: one item per cycle while req_if.ready is high. A result passes the
// registered permutation read, the dependent registered frame store read and the
// output queue register before it is offered on rsp_if.
// A 4-entry output queue decouples the sides; req_if.ready drops only when the
// queue plus the items in flight would fill it, so a stalled receiver holds
// the input back after at most a few items. Reset clears the counters, sets the
// registers to defaults; both memories come up undefined and need no clearing.
`default_nettype none

module cell_interleaver_core #(
   parameter int unsigned MAX_CELLS = cil_pkg::CIL_MAX_CELLS,
   parameter int unsigned MAX_DEPTH = cil_pkg::CIL_MAX_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   cil_req_if.sink                           req_if,
   cil_rsp_if.source                         rsp_if,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [cil_pkg::CIL_ADDR_W-1:0] csr_paddr,
   input  wire logic [cil_pkg::CIL_DATA_W-1:0] csr_pwdata,
   output logic      [cil_pkg::CIL_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);
   import cil_pkg::*;

   localparam int unsigned CW      = $clog2(MAX_CELLS);
   localparam int unsigned LW      = $clog2(MAX_CELLS + 1);
   localparam int unsigned SW      = $clog2(MAX_DEPTH + 1);
   localparam int unsigned FS_DEPTH = (MAX_DEPTH + 1) * MAX_CELLS;
   localparam int unsigned FA      = $clog2(FS_DEPTH);
   localparam int unsigned PW      = $clog2(CIL_OUT_DEPTH);
   localparam int unsigned QW      = $clog2(CIL_OUT_DEPTH + 1);

   // configuration registers
   logic [12:0] frame_length_ff;
   logic        long_mode_ff;
   logic [3:0]  depth_ff;
   logic        cfg_write;
   logic [CIL_IDX_W-1:0] cfg_idx;

   // stream counters
   logic [CW-1:0] pos_ff, pos_in;
   logic [SW-1:0] phase_ff, phase_in;
   logic [SW-1:0] wslot_ff, wslot_in;
   logic [SW-1:0] done_ff, done_in;

   logic [LW-1:0] len;
   logic [SW-1:0] depth_eff;
   logic [SW:0]   slots;
   logic [SW-1:0] newest;
   logic [SW:0]   diff;
   logic [SW-1:0] rslot;
   logic [LW-1:0] pos_next;
   logic          frame_last;
   logic          emit;
   logic          take;
   logic          take_cell;

   // stage 1: permutation read in flight
   logic          s1_valid_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic [SW-1:0] s1_rslot_ff;
   logic [SW-1:0] s1_wslot_ff;
   logic [CW-1:0] s1_pos_ff;
   logic [31:0]   s1_cell_ff;
   logic [11:0]   perm_rdata;
   logic          src_ok;
   logic [FA-1:0] fs_rd_addr;
   logic [FA-1:0] fs_wr_addr;

   // stage 2: frame store read in flight
   logic          s2_emit_ff;
   logic          s2_zero_ff;
   logic          s2_last_ff;
   logic [31:0]   fs_rdata;

   // output queue
   cil_cell_type  q_mem_ff [CIL_OUT_DEPTH];
   cil_cell_type  push_cell;
   logic [PW-1:0] q_wr_ff;
   logic [PW-1:0] q_rd_ff;
   logic [QW-1:0] q_cnt_ff;
   logic          q_push;
   logic          q_pop;
   logic [QW+1:0] credit;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[CIL_IDX_W+1:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (cfg_idx == REG_FRAME_LENGTH || cfg_idx == REG_LONG_MODE
                           || cfg_idx == REG_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= RST_FRAME_LENGTH;
         long_mode_ff    <= RST_LONG_MODE;
         depth_ff        <= RST_DEPTH;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (cfg_idx)
            REG_FRAME_LENGTH: frame_length_ff <= csr_pwdata[12:0];
            REG_LONG_MODE:    long_mode_ff    <= csr_pwdata[0];
            REG_DEPTH:        depth_ff        <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (cfg_idx)
         REG_FRAME_LENGTH: csr_prdata[12:0] = frame_length_ff;
         REG_LONG_MODE:    csr_prdata[0]    = long_mode_ff;
         REG_DEPTH:        csr_prdata[3:0]  = depth_ff;
         default:          csr_prdata       = '0;
      endcase
   end

   // ---------------- effective geometry ----------------
   always_comb begin
      if (frame_length_ff == 13'd0) begin
         len = LW'(1);
      end else if (int'(frame_length_ff) > int'(MAX_CELLS)) begin
         len = LW'(MAX_CELLS);
      end else begin
         len = LW'(frame_length_ff);
      end

      if (!long_mode_ff || depth_ff == 4'd0) begin
         depth_eff = SW'(1);
      end else if (int'(depth_ff) > int'(MAX_DEPTH)) begin
         depth_eff = SW'(MAX_DEPTH);
      end else begin
         depth_eff = SW'(depth_ff);
      end
      slots = {1'b0, depth_eff} + (SW+1)'(1);
   end

   // ---------------- stage 0: accept, counters, table access ----------------
   assign take      = req_if.valid && req_if.ready;
   assign take_cell = take && (req_if.op == OP_CELL);
   assign emit      = done_ff >= depth_eff;

   always_comb begin
      newest = (wslot_ff == '0) ? depth_eff : wslot_ff - SW'(1);
      diff   = {1'b0, newest} + slots - {1'b0, phase_ff};
      rslot  = (diff >= slots) ? SW'(diff - slots) : SW'(diff);

      pos_next   = LW'(pos_ff) + LW'(1);
      frame_last = pos_next == len;

      pos_in   = pos_ff;
      phase_in = phase_ff;
      wslot_in = wslot_ff;
      done_in  = done_ff;
      if (cfg_write) begin
         pos_in   = '0;
         phase_in = '0;
         wslot_in = '0;
         done_in  = '0;
      end else if (take_cell) begin
         if (frame_last) begin
            pos_in   = '0;
            phase_in = '0;
            wslot_in = (wslot_ff == depth_eff) ? '0 : wslot_ff + SW'(1);
            done_in  = (done_ff < depth_eff) ? done_ff + SW'(1) : done_ff;
         end else begin
            pos_in   = CW'(pos_next);
            phase_in = (phase_ff + SW'(1) == depth_eff) ? '0 : phase_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
         wslot_ff <= '0;
         done_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         wslot_ff <= wslot_in;
         done_ff  <= done_in;
      end
   end

   cil_ram #(
      .WIDTH (12),
      .DEPTH (MAX_CELLS)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (take && (req_if.op == OP_LOAD)
                && (int'(req_if.table_index) < int'(MAX_CELLS))),
      .wr_addr (CW'(req_if.table_index)),
      .wr_data (req_if.table_value),
      .rd_addr (pos_ff),
      .rd_data (perm_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= take_cell;
         s1_emit_ff  <= take_cell && emit;
      end
      s1_last_ff  <= frame_last;
      s1_rslot_ff <= rslot;
      s1_wslot_ff <= wslot_ff;
      s1_pos_ff   <= pos_ff;
      s1_cell_ff  <= {req_if.in_q, req_if.in_i};
   end

   // ---------------- stage 1: frame store read and write ----------------
   assign src_ok     = 32'(perm_rdata) < 32'(len);
   assign fs_rd_addr = FA'(FA'(s1_rslot_ff) * FA'(MAX_CELLS)) + FA'(perm_rdata);
   assign fs_wr_addr = FA'(FA'(s1_wslot_ff) * FA'(MAX_CELLS)) + FA'(s1_pos_ff);

   cil_ram #(
      .WIDTH (32),
      .DEPTH (FS_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (fs_wr_addr),
      .wr_data (s1_cell_ff),
      .rd_addr (fs_rd_addr),
      .rd_data (fs_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
      s2_zero_ff <= !src_ok;
      s2_last_ff <= s1_last_ff;
   end

   // ---------------- stage 2: output queue ----------------
   always_comb begin
      push_cell.out_i     = s2_zero_ff ? 16'sd0 : signed'(fs_rdata[15:0]);
      push_cell.out_q     = s2_zero_ff ? 16'sd0 : signed'(fs_rdata[31:16]);
      push_cell.frame_end = s2_last_ff;
   end

   assign q_push = s2_emit_ff;
   assign q_pop  = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (q_push) begin
            q_wr_ff <= q_wr_ff + PW'(1);
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + PW'(1);
         end
         q_cnt_ff <= q_cnt_ff + QW'(q_push) - QW'(q_pop);
      end
      if (q_push) begin
         q_mem_ff[q_wr_ff] <= push_cell;
      end
   end

   assign credit = (QW+2)'(q_cnt_ff) + (QW+2)'(s1_emit_ff) + (QW+2)'(s2_emit_ff);

   assign req_if.ready     = credit < (QW+2)'(CIL_OUT_DEPTH);
   assign rsp_if.valid     = q_cnt_ff != '0;
   assign rsp_if.out_i     = q_mem_ff[q_rd_ff].out_i;
   assign rsp_if.out_q     = q_mem_ff[q_rd_ff].out_q;
   assign rsp_if.frame_end = q_mem_ff[q_rd_ff].frame_end;

endmodule

`default_nettype wire

/* verif/cil_checker.sv */
// Result checker for cell_interleaver_core: mirrors the register writes, keeps its own copy
// of the permutation table and frame store, predicts every interleaved cell and compares.
// Depends on cil_pkg and the cil_req_if / cil_rsp_if interfaces.
module cil_checker
   import cil_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cil_req_if                    req,
   cil_rsp_if                    rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CIL_ADDR_W-1:0] csr_paddr,
   input  logic [CIL_DATA_W-1:0] csr_pwdata,
   output int                    mismatches,
   output int                    cells_due
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [11:0] perm_map [CIL_MAX_CELLS];
   logic [31:0] cell_store [(CIL_MAX_DEPTH+1)*CIL_MAX_CELLS];

   logic [12:0] len_reg;
   logic        long_reg;
   logic [3:0]  depth_reg;

   int unsigned pos, phase, wslot, filled;
   cil_cell_type due_q[$];
   int errs = 0;

   function automatic int unsigned frame_cells();
      if (len_reg == 0) return 1;
      if (len_reg > CIL_MAX_CELLS) return CIL_MAX_CELLS;
      return 32'(len_reg);
   endfunction

   function automatic int unsigned span_frames();
      if (!long_reg || depth_reg == 0) return 1;
      if (depth_reg > CIL_MAX_DEPTH) return CIL_MAX_DEPTH;
      return 32'(depth_reg);
   endfunction

   task automatic restart_stream();
      pos    = 0;
      phase  = 0;
      wslot  = 0;
      filled = 0;
   endtask

   task automatic flag(string what, int want, int got);
      errs++;
      if (errs <= 10) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      end
   endtask

   task automatic interleave_cell(logic signed [15:0] ci, logic signed [15:0] cq);
      int unsigned len, dep, slots, newest, slot, src;
      logic [31:0] word;
      cil_cell_type res;
      len   = frame_cells();
      dep   = span_frames();
      slots = dep + 1;
      if (filled >= dep) begin
         newest = (wslot == 0) ? dep : wslot - 1;
         slot   = (newest + slots - phase) % slots;
         src    = 32'(perm_map[pos]);
         word   = (src < len) ? cell_store[slot*CIL_MAX_CELLS + src] : '0;
         res.out_i     = word[15:0];
         res.out_q     = word[31:16];
         res.frame_end = (pos == len - 1);
         due_q = {due_q, res};
      end
      cell_store[wslot*CIL_MAX_CELLS + pos] = {cq, ci};
      phase = (phase + 1 == dep) ? 0 : phase + 1;
      pos++;
      if (pos >= len) begin
         pos   = 0;
         phase = 0;
         wslot = (wslot == dep) ? 0 : wslot + 1;
         if (filled < dep) filled++;
      end
   endtask

   always @(posedge clock) begin
      cil_cell_type want;
      if (reset) begin
         len_reg   = RST_FRAME_LENGTH;
         long_reg  = RST_LONG_MODE;
         depth_reg = RST_DEPTH;
         restart_stream();
         due_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (due_q.size() == 0) begin
               errs++;
               if (errs <= 10) begin
                  $display("%0t: result with nothing due: i %0d q %0d end %0d",
                           $time, rsp.out_i, rsp.out_q, rsp.frame_end);
               end
            end else begin
               want = due_q.pop_front();
               if (rsp.out_i !== want.out_i)
                  flag("out_i", int'(want.out_i), int'(rsp.out_i));
               if (rsp.out_q !== want.out_q)
                  flag("out_q", int'(want.out_q), int'(rsp.out_q));
               if (rsp.frame_end !== want.frame_end)
                  flag("frame_end", int'(want.frame_end), int'(rsp.frame_end));
            end
         end
         if (req.valid && req.ready) begin
            if (req.op == OP_CELL) interleave_cell(req.in_i, req.in_q);
            else perm_map[req.table_index] = req.table_value;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CIL_ADDR_W-1:2])
               REG_FRAME_LENGTH: begin
                  len_reg = csr_pwdata[12:0];
                  restart_stream();
               end
               REG_LONG_MODE: begin
                  long_reg = csr_pwdata[0];
                  restart_stream();
               end
               REG_DEPTH: begin
                  depth_reg = csr_pwdata[3:0];
                  restart_stream();
               end
               default: ;
            endcase
         end
      end
      mismatches <= errs;
      cells_due  <= due_q.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top for cell_interleaver_core: clock, reset, register writes, item stimulus
// with random idling on both channels, watchdog and verdict. Checking sits in cil_checker.
// Depends on cil_pkg, cil_if, cil_checker and the rtl.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cil_pkg::*;

   localparam int unsigned STALL_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CIL_ADDR_W-1:0] csr_paddr;
   logic [CIL_DATA_W-1:0] csr_pwdata;
   logic [CIL_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          mismatches;
   int          cells_due;
   int          send_gap_pct = 22;
   int          take_gap_pct = 49;
   int unsigned stall_cycles = 0;
   int unsigned random_items = 0;

   cil_req_if req_ch();
   cil_rsp_if rsp_ch();

   cell_interleaver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cil_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .cells_due   (cells_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= take_gap_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send(logic op, int unsigned idx, int unsigned val, int ci, int cq);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.table_index <= 12'(idx);
      req_ch.table_value <= 12'(val);
      req_ch.in_i        <= 16'(ci);
      req_ch.in_q        <= 16'(cq);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the sender until every due cell has come back, then cover the pipeline
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (cells_due != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CIL_IDX_W-1:0] idx, int unsigned value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic int unsigned pick_source(int unsigned len);
      if ($urandom_range(99) < 10) return $urandom_range(4095);
      return $urandom_range(len - 1);
   endfunction

   // perm entries are loaded first for the positions that output frames will reach; random loads follow among the cells
   task automatic run_stream(int unsigned len_v, bit long_v, int unsigned depth_v,
                             int unsigned out_cells);
      int unsigned len, dep, n, c;
      len = (len_v == 0) ? 1 : (len_v > CIL_MAX_CELLS) ? CIL_MAX_CELLS : len_v;
      dep = (!long_v || depth_v == 0) ? 1 : (depth_v > CIL_MAX_DEPTH) ? CIL_MAX_DEPTH : depth_v;
      write_reg(REG_FRAME_LENGTH, len_v);
      write_reg(REG_LONG_MODE, 32'(long_v));
      write_reg(REG_DEPTH, depth_v);
      n = (out_cells < len) ? out_cells : len;
      for (int unsigned p = 0; p < n; p++) begin
         send(OP_LOAD, p, pick_source(len), $urandom, $urandom);
         random_items++;
      end
      c = 0;
      while (c < len*dep + out_cells) begin
         if ($urandom_range(99) < 12) begin
            send(OP_LOAD, $urandom, pick_source(len), $urandom, $urandom);
         end else begin
            send(OP_CELL, $urandom, $urandom, $urandom, $urandom);
            c++;
         end
         random_items++;
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_LOAD;
      req_ch.table_index <= '0;
      req_ch.table_value <= '0;
      req_ch.in_i        <= '0;
      req_ch.in_q        <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // three-cell frames, short mode; last position points past the frame
      write_reg(REG_FRAME_LENGTH, 3);
      write_reg(REG_LONG_MODE, 0);
      send(OP_LOAD, 0, 2, 0, 0);
      send(OP_LOAD, 1, 0, 0, 0);
      send(OP_LOAD, 2, 4095, -1, -1);
      send(OP_LOAD, 4095, 4095, 0, 0);
      send(OP_CELL, 0, 0, -32768, 32767);
      send(OP_CELL, 0, 0, 32767, -32768);
      send(OP_CELL, 0, 0, 0, -1);
      send(OP_CELL, 0, 0, 1, -1);
      send(OP_CELL, 0, 0, -1, 0);
      send(OP_CELL, 0, 0, 12345, -12345);

      // zero frame length acts as one cell per frame
      write_reg(REG_FRAME_LENGTH, 0);
      send(OP_LOAD, 0, 0, 0, 0);
      send(OP_CELL, 0, 0, 100, -100);
      send(OP_CELL, 0, 0, -32768, -32768);
      send(OP_CELL, 0, 0, 32767, 32767);

      // long mode, depth zero acts as one, then depth above range acts as eight
      write_reg(REG_LONG_MODE, 1);
      write_reg(REG_DEPTH, 0);
      send(OP_CELL, 0, 0, 7, 8);
      send(OP_CELL, 0, 0, 9, 10);
      send(OP_CELL, 0, 0, 11, 12);
      write_reg(REG_DEPTH, 15);
      for (int k = 0; k < 9; k++) send(OP_CELL, 0, 0, k * 1000 - 4000, 3000 - k * 700);

      random_items = 0;
      while (random_items < 1000) begin
         if (random_items >= 667) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end else if (random_items >= 333) begin
            send_gap_pct = 49;
            take_gap_pct = 22;
         end
         run_stream(($urandom_range(99) < 10) ? $urandom_range(1) : $urandom_range(2, 12),
                    1'($urandom_range(1)), $urandom_range(15), $urandom_range(1, 48));
      end

      // frame length above range, then at the maximum: five cells into each clamped frame
      write_reg(REG_FRAME_LENGTH, 8191);
      for (int k = 0; k < 5; k++) send(OP_CELL, $urandom, $urandom, $urandom, $urandom);
      write_reg(REG_FRAME_LENGTH, 4096);
      for (int k = 0; k < 5; k++) send(OP_CELL, $urandom, $urandom, $urandom, $urandom);

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (cells_due != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && cells_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/cil_pkg.sv
rtl/cil_if.sv
rtl/cil_ram.sv
rtl/cell_interleaver_core.sv
verif/cil_checker.sv
verif/tb_top.sv
